// ===== hw/rtl/kdqs_pkg.sv =====
package kdqs_pkg;

    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;
    localparam int NAME_W   = 64;
    localparam int PRICE_W  = 20;

    // request codes; 6 and 7 are unused and answered with done
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_SEARCH     = 3'd4,
        KIND_LIST       = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 3'd0,
        STAT_OVERFLOW  = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_FOUND     = 3'd3,
        STAT_NOT_FOUND = 3'd4,
        STAT_LISTED    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK
    } state_t;

endpackage

// ===== hw/rtl/kdqs_intf.sv =====
interface kdqs_req_if;
    import kdqs_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [NAME_W-1:0]   item_name;
    logic [PRICE_W-1:0]  item_price;

    modport source (output valid, kind, item_name, item_price, input ready);
    modport sink   (input valid, kind, item_name, item_price, output ready);
endinterface

interface kdqs_rsp_if;
    import kdqs_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [NAME_W-1:0]   found_name;
    logic [PRICE_W-1:0]  found_price;
    logic                last_result;

    modport source (output valid, status, found_name, found_price, last_result, input ready);
    modport sink   (input valid, status, found_name, found_price, last_result, output ready);
endinterface

// ===== hw/rtl/keyed_deque_with_search_core.sv =====
// bounded double-ended queue of name / price entries with a linear name search
//
// req channel: one beat per request (kind, item_name, item_price); push front,
//   push back, pop front, pop back, search for a name, or list all entries
// rsp channel: status, found_name, found_price, last_result; one beat per
//   request, except list on a non-empty queue, which gives one beat per entry
//   from front to back with last_result only on the final beat
// sequence: push, pop and unknown kinds answer on the cycle after acceptance;
//   a search reads each entry from memory, then compares it with the key,
//   and answers right after the matching or final entry; a list reads and
//   emits each entry in turn, from front to back
// throughput: one request at a time; req.ready is high only while the
//   sequencer is idle and the result register is empty. the entry memory's
//   one read port and its one comparator set the per-entry pace
// stalls: a held rsp beat freezes the list walk; no beat is dropped
// reset: front pointer and fill count clear, the queue is empty; entry
//   storage is not cleared since only occupied entries are ever read
module keyed_deque_with_search_core #(
    parameter int DEPTH      = 32,
    parameter int NAME_BYTES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    kdqs_req_if.sink          req,
    kdqs_rsp_if.source        rsp
);
    import kdqs_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} >> (NAME_W - 8 * NAME_BYTES);

    // entry memory: one write port, one registered read port
    logic [NAME_W-1:0]  name_mem  [DEPTH];
    logic [PRICE_W-1:0] price_mem [DEPTH];
    logic [NAME_W-1:0]  rd_name_reg;
    logic [PRICE_W-1:0] rd_price_reg;
    logic               mem_we;
    logic               mem_re;
    logic [IDX_W-1:0]   wr_addr;

    // sequencer and queue pointers
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   ofs_reg, ofs_next;
    logic               is_list_reg, is_list_next;
    logic [NAME_W-1:0]  key_reg, key_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    logic [NAME_W-1:0]  out_name_reg, out_name_next;
    logic [PRICE_W-1:0] out_price_reg, out_price_next;
    logic               out_last_reg, out_last_next;

    // shared ring adder: front + offset, wrapped into DEPTH
    logic [IDX_W-1:0]   ring_ofs;
    logic [IDX_W:0]     ring_sum;
    logic [IDX_W-1:0]   slot;

    logic [IDX_W-1:0]   front_dec;
    logic [IDX_W-1:0]   front_inc;
    logic               is_full;
    logic               is_empty;
    logic               at_last;
    logic               out_free;
    logic               accept;
    logic [NAME_W-1:0]  in_name;
    kind_t              in_kind;

    // in idle the adder finds the back slot, while walking it finds the entry
    assign ring_ofs  = (state_reg == ST_IDLE) ? IDX_W'(count_reg) : ofs_reg;
    assign ring_sum  = {1'b0, front_reg} + {1'b0, ring_ofs};
    assign slot      = (ring_sum >= (IDX_W+1)'(DEPTH)) ?
                       IDX_W'(ring_sum - (IDX_W+1)'(DEPTH)) : ring_sum[IDX_W-1:0];

    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign at_last   = ((CNT_W'(ofs_reg) + CNT_W'(1)) == count_reg);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign req.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept    = req.valid && req.ready;
    assign in_name   = req.item_name & NAME_MASK;
    assign in_kind   = kind_t'(req.kind);

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found_name  = out_name_reg;
    assign rsp.found_price = out_price_reg;
    assign rsp.last_result = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            name_mem[wr_addr]  <= in_name;
            price_mem[wr_addr] <= req.item_price;
        end
        if (mem_re)
        begin
            rd_name_reg  <= name_mem[slot];
            rd_price_reg <= price_mem[slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            ofs_reg       <= '0;
            is_list_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            ofs_reg       <= ofs_next;
            is_list_reg   <= is_list_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        status_reg    <= status_next;
        out_name_reg  <= out_name_next;
        out_price_reg <= out_price_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        logic out_load;

        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        ofs_next       = ofs_reg;
        is_list_next   = is_list_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        out_name_next  = out_name_reg;
        out_price_next = out_price_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        wr_addr        = slot;
        out_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_load       = 1'b1;
                    status_next    = STAT_DONE;
                    out_name_next  = '0;
                    out_price_next = '0;
                    out_last_next  = 1'b1;
                    unique case (in_kind)
                        KIND_PUSH_FRONT, KIND_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = STAT_OVERFLOW;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (in_kind == KIND_PUSH_FRONT)
                                begin
                                    wr_addr    = front_dec;
                                    front_next = front_dec;
                                end
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                if (in_kind == KIND_POP_FRONT)
                                begin
                                    front_next = front_inc;
                                end
                            end
                        end
                        KIND_SEARCH, KIND_LIST:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                // start the walk, no result yet
                                out_load     = 1'b0;
                                key_next     = in_name;
                                is_list_next = (in_kind == KIND_LIST);
                                ofs_next     = '0;
                                state_next   = ST_READ;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_DONE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!is_list_reg)
                begin
                    if (rd_name_reg == key_reg)
                    begin
                        out_load       = 1'b1;
                        status_next    = STAT_FOUND;
                        out_name_next  = rd_name_reg;
                        out_price_next = rd_price_reg;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else if (at_last)
                    begin
                        out_load       = 1'b1;
                        status_next    = STAT_NOT_FOUND;
                        out_name_next  = '0;
                        out_price_next = '0;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        ofs_next   = ofs_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
                else if (out_free)
                begin
                    out_load       = 1'b1;
                    status_next    = STAT_LISTED;
                    out_name_next  = rd_name_reg;
                    out_price_next = rd_price_reg;
                    out_last_next  = at_last;
                    if (at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ofs_next   = ofs_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // a pending result always blocks new requests
    assert property (@(posedge clk) disable iff (!rst_n) rsp.valid |-> !req.ready)
        else $error("request accepted while a result is pending");

    // fill count stays within the ring
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // front pointer stays within the ring
    assert property (@(posedge clk) disable iff (!rst_n) front_reg <= IDX_W'(DEPTH - 1))
        else $error("front pointer out of range");

    // non-walking requests answer with a single final beat on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.kind != KIND_SEARCH) && (req.kind != KIND_LIST))
        |=> (rsp.valid && rsp.last_result && (state_reg == ST_IDLE)))
        else $error("single-beat request did not answer at once");

endmodule
